[rtl/rmx_pkg.sv]
// Shared types, constants and round functions of the reversible 128-bit mixer.
// No dependencies; every rtl file refers to it by scoped names.
package rmx_pkg;

  localparam int unsigned NumWords  = 4;
  localparam int unsigned WordBits  = 32;
  localparam int unsigned NumRounds = 8;

  typedef logic [WordBits-1:0] word_t;
  typedef word_t [NumWords-1:0] block_t;   // index 0 is word a

  typedef enum logic [1:0] {
    ACT_MIX      = 2'd0,
    ACT_UNMIX    = 2'd1,
    ACT_HALF_FWD = 2'd2,
    ACT_HALF_INV = 2'd3
  } action_t;

  typedef struct packed {
    action_t action;
    word_t   word_a_in;
    word_t   word_b_in;
    word_t   word_c_in;
    word_t   word_d_in;
  } in_beat_t;

  typedef struct packed {
    word_t word_a_out;
    word_t word_b_out;
    word_t word_c_out;
    word_t word_d_out;
  } out_beat_t;

  // beat as it travels down the row of cells
  typedef struct packed {
    action_t action;
    block_t  w;
  } beat_t;

  localparam int unsigned SHIFT_AMT [NumRounds] = '{7, 13, 17, 9, 3, 7, 15, 11};

  function automatic word_t xs_fwd(word_t v, int unsigned s, logic right);
    return right ? (v ^ (v >> s)) : (v ^ (v << s));
  endfunction

  // true inverse of v ^= v >> s (or << s): xor of all multiples of the shift
  function automatic word_t xs_inv(word_t y, int unsigned s, logic right);
    word_t x;
    x = y;
    for (int unsigned j = 1; j < WordBits; j++) begin
      if (j * s < WordBits) begin
        x = x ^ (right ? (y >> (j * s)) : (y << (j * s)));
      end
    end
    return x;
  endfunction

  function automatic block_t round_fwd(block_t w, int unsigned r);
    logic [2:0] rr;
    logic [1:0] t;
    logic [1:0] p;
    block_t     o;
    rr = r[2:0];
    t  = rr[1:0];
    p  = rr[1:0] + 2'd3;
    o  = w;
    o[t] = o[t] + o[p];
    o[p] = o[p] + o[t];
    o[t] = xs_fwd(o[t], SHIFT_AMT[rr], !t[0]);
    return o;
  endfunction

  function automatic block_t round_inv(block_t w, int unsigned r);
    logic [2:0] rr;
    logic [1:0] t;
    logic [1:0] p;
    block_t     o;
    rr = r[2:0];
    t  = rr[1:0];
    p  = rr[1:0] + 2'd3;
    o  = w;
    o[t] = xs_inv(o[t], SHIFT_AMT[rr], !t[0]);
    o[p] = o[p] - o[t];
    o[t] = o[t] - o[p];
    return o;
  endfunction

endpackage

[rtl/rmx_cell.sv]
// One mixer cell: a registered stage doing one round, forward or inverse, or none.
// Depends on rmx_pkg.
module rmx_cell #(
  parameter int unsigned STAGE = 0
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          up_valid,
  output logic          up_ready,
  input  rmx_pkg::beat_t up_beat,
  output logic          dn_valid,
  input  logic          dn_ready,
  output rmx_pkg::beat_t dn_beat
);

  // forward pass runs rounds in order, inverse pass runs them backwards
  localparam int unsigned FwdRound   = STAGE;
  localparam int unsigned InvRound   = rmx_pkg::NumRounds - 1 - STAGE;
  localparam logic        FirstHalf  = (STAGE < rmx_pkg::NumRounds / 2);

  logic           valid;
  rmx_pkg::beat_t beat;
  rmx_pkg::beat_t beat_next;
  logic           inverse;
  logic           half;

  always_comb begin
    inverse = (up_beat.action == rmx_pkg::ACT_UNMIX) ||
              (up_beat.action == rmx_pkg::ACT_HALF_INV);
    half    = (up_beat.action == rmx_pkg::ACT_HALF_FWD) ||
              (up_beat.action == rmx_pkg::ACT_HALF_INV);
    beat_next = up_beat;
    if (!(half && FirstHalf)) begin
      if (inverse) begin
        beat_next.w = rmx_pkg::round_inv(up_beat.w, InvRound);
      end else begin
        beat_next.w = rmx_pkg::round_fwd(up_beat.w, FwdRound);
      end
    end
  end

  assign up_ready = !valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      beat <= beat_next;
    end
  end

  assign dn_valid = valid;
  assign dn_beat  = beat;

endmodule

[rtl/reversible_128bit_mixer_core.sv]
// Top level of the reversible 128-bit add/xorshift mixer.
// Depends on rmx_pkg and rmx_cell.

// Eight cells in a row, one round per cell, each a register stage. A beat enters every
// clock while in_ready is high, and its result leaves from the last cell, which is the
// output register. A stalled output holds its beat while the cells behind it keep
// filling, so the input only stops once every cell is full. Actions: mix runs all eight
// rounds, unmix their exact inverse, half-forward rounds four to seven, half-inverse
// undoes rounds three down to nought; cells without a round for the action pass the
// beat through unchanged.
module reversible_128bit_mixer_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  rmx_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output rmx_pkg::out_beat_t out_data
);

  localparam int unsigned Cells = rmx_pkg::NumRounds;

  logic           vld [Cells+1];
  logic           rdy [Cells+1];
  rmx_pkg::beat_t bt  [Cells+1];
  logic [Cells-1:0] occ;

  assign vld[0]      = in_valid;
  assign in_ready    = rdy[0];
  assign bt[0].action = in_data.action;
  assign bt[0].w[0]  = in_data.word_a_in;
  assign bt[0].w[1]  = in_data.word_b_in;
  assign bt[0].w[2]  = in_data.word_c_in;
  assign bt[0].w[3]  = in_data.word_d_in;

  for (genvar k = 0; k < Cells; k++) begin : g_cell
    rmx_cell #(.STAGE(k)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .up_valid (vld[k]),
      .up_ready (rdy[k]),
      .up_beat  (bt[k]),
      .dn_valid (vld[k+1]),
      .dn_ready (rdy[k+1]),
      .dn_beat  (bt[k+1])
    );
    assign occ[k] = vld[k+1];
  end

  assign out_valid           = vld[Cells];
  assign rdy[Cells]          = out_ready;
  assign out_data.word_a_out = bt[Cells].w[0];
  assign out_data.word_b_out = bt[Cells].w[1];
  assign out_data.word_c_out = bt[Cells].w[2];
  assign out_data.word_d_out = bt[Cells].w[3];

  // a free output slot means every cell can shift
  a_ready_when_free: assert property (@(posedge clk) disable iff (rst)
    (!out_valid || out_ready) |-> in_ready)
    else $error("input stalled with output slot free");

  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> occ[0])
    else $error("accepted beat missing from first cell");

  a_drain_count: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !(in_valid && in_ready)) |=>
      ($countones(occ) + 1 == $past($countones(occ))))
    else $error("beat lost or duplicated while draining");

  a_fill_count: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && !(out_valid && out_ready)) |=>
      ($countones(occ) == $past($countones(occ)) + 1))
    else $error("beat lost or duplicated while filling");

endmodule

[dv/tb_reversible_128bit_mixer_core.sv]
`timescale 1ns / 100ps
// Testbench for reversible_128bit_mixer_core: a cycle-free predictor of the add/xorshift
// rounds checks every output beat in order under random gaps and output stalls.
// Depends on rmx_pkg (beat types, action codes) and the core itself.

module tb_reversible_128bit_mixer_core;

  localparam int unsigned HOLD_OFF_CYCLES = 150;
  localparam int unsigned WATCHDOG_LIMIT  = 1000;
  localparam int unsigned DRAIN_CYCLES    = 16;

  typedef logic [3:0][31:0] quad_t;   // [0] is word a

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  rmx_pkg::in_beat_t  in_data;
  logic               out_valid;
  logic               out_ready;
  rmx_pkg::out_beat_t out_data;

  rmx_pkg::out_beat_t expected_blocks[$];
  int unsigned blocks_sent;
  int unsigned blocks_checked;
  int unsigned mismatches;
  int unsigned sent_per_action[4];
  int unsigned quiet_cycles;
  bit          tx_idle_en   = 1'b1;
  bit          rx_stall_en  = 1'b1;
  bit          hold_off_req = 1'b0;   // toggled once per requested hold-off

  reversible_128bit_mixer_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  function automatic int unsigned round_shift(int unsigned r);
    case (r)
      0: return 7;
      1: return 13;
      2: return 17;
      3: return 9;
      4: return 3;
      5: return 7;
      6: return 15;
      default: return 11;
    endcase
  endfunction

  function automatic rmx_pkg::word_t xorshift(rmx_pkg::word_t v, int unsigned s, bit right);
    return right ? (v ^ (v >> s)) : (v ^ (v << s));
  endfunction

  // refold until every bit position has been reached by a multiple of the shift
  function automatic rmx_pkg::word_t unxorshift(rmx_pkg::word_t y, int unsigned s,
                                                bit right);
    rmx_pkg::word_t x;
    int unsigned    covered;
    x = y;
    for (covered = s; covered < 32; covered += s) begin
      x = right ? (y ^ (x >> s)) : (y ^ (x << s));
    end
    return x;
  endfunction

  // round r: target t = r mod 4, predecessor t-1; words a and c shift right
  function automatic quad_t mix_round(quad_t q, int unsigned r);
    int unsigned t;
    int unsigned p;
    t = r % 4;
    p = (r + 3) % 4;
    q[t] = q[t] + q[p];
    q[p] = q[p] + q[t];
    q[t] = xorshift(q[t], round_shift(r), (t % 2) == 0);
    return q;
  endfunction

  function automatic quad_t unmix_round(quad_t q, int unsigned r);
    int unsigned t;
    int unsigned p;
    t = r % 4;
    p = (r + 3) % 4;
    q[t] = unxorshift(q[t], round_shift(r), (t % 2) == 0);
    q[p] = q[p] - q[t];
    q[t] = q[t] - q[p];
    return q;
  endfunction

  function automatic rmx_pkg::out_beat_t mixed_block(rmx_pkg::in_beat_t b);
    quad_t              q;
    rmx_pkg::out_beat_t o;
    int                 r;
    q = {b.word_d_in, b.word_c_in, b.word_b_in, b.word_a_in};
    case (b.action)
      rmx_pkg::ACT_MIX:      for (r = 0; r < 8; r++) q = mix_round(q, r);
      rmx_pkg::ACT_UNMIX:    for (r = 7; r >= 0; r--) q = unmix_round(q, r);
      rmx_pkg::ACT_HALF_FWD: for (r = 4; r < 8; r++) q = mix_round(q, r);
      rmx_pkg::ACT_HALF_INV: for (r = 3; r >= 0; r--) q = unmix_round(q, r);
      default:               ;
    endcase
    o.word_a_out = q[0];
    o.word_b_out = q[1];
    o.word_c_out = q[2];
    o.word_d_out = q[3];
    return o;
  endfunction

  // ---------------------------------------------------------------- helpers

  // mostly short gaps, now and then a long one
  function automatic int unsigned idle_len();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 75) return $urandom_range(1, 3);
    if (roll < 93) return $urandom_range(4, 9);
    return $urandom_range(10, 40);
  endfunction

  function automatic rmx_pkg::word_t rand_word();
    int unsigned roll;
    roll = $urandom_range(0, 19);
    case (roll)
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h1 << $urandom_range(0, 31);
      3:       return ~(32'h1 << $urandom_range(0, 31));
      default: return $urandom;
    endcase
  endfunction

  task automatic send_block(input rmx_pkg::action_t act, input rmx_pkg::word_t a,
                            input rmx_pkg::word_t b, input rmx_pkg::word_t c,
                            input rmx_pkg::word_t d);
    int unsigned       gap;
    rmx_pkg::in_beat_t beat;
    gap = (tx_idle_en && $urandom_range(0, 2) == 0) ? idle_len() : 0;
    beat.action    = act;
    beat.word_a_in = a;
    beat.word_b_in = b;
    beat.word_c_in = c;
    beat.word_d_in = d;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_blocks.push_back(mixed_block(beat));
    blocks_sent++;
    sent_per_action[act]++;
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (expected_blocks.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_directed_extremes();
    rmx_pkg::word_t w[4];
    int             act;
    int             pat;
    for (act = 0; act < 4; act++) begin
      for (pat = 0; pat < 6; pat++) begin
        case (pat)
          0: w = '{32'h0, 32'h0, 32'h0, 32'h0};
          1: w = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
          2: w = '{32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA};
          3: w = '{32'h1, 32'h1, 32'h1, 32'h1};
          4: w = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
          default: w = '{32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h0};
        endcase
        send_block(rmx_pkg::action_t'(act), w[0], w[1], w[2], w[3]);
      end
    end
  endtask

  // a block followed by its own image under the opposite action
  task automatic test_inverse_pairs();
    rmx_pkg::in_beat_t  b;
    rmx_pkg::out_beat_t m;
    int                 i;
    for (i = 0; i < 100; i++) begin
      b.action    = (i % 2 == 0) ? rmx_pkg::ACT_MIX : rmx_pkg::ACT_UNMIX;
      b.word_a_in = rand_word();
      b.word_b_in = rand_word();
      b.word_c_in = rand_word();
      b.word_d_in = rand_word();
      m = mixed_block(b);
      send_block(b.action, b.word_a_in, b.word_b_in, b.word_c_in, b.word_d_in);
      send_block((b.action == rmx_pkg::ACT_MIX) ? rmx_pkg::ACT_UNMIX : rmx_pkg::ACT_MIX,
                 m.word_a_out, m.word_b_out, m.word_c_out, m.word_d_out);
    end
  endtask

  // receiver holds off long enough that every cell fills and the input stalls
  task automatic test_output_hold_off();
    int i;
    tx_idle_en   = 1'b0;
    hold_off_req = !hold_off_req;
    for (i = 0; i < 40; i++) begin
      send_block(rmx_pkg::action_t'($urandom_range(0, 3)), rand_word(), rand_word(),
                 rand_word(), rand_word());
    end
    tx_idle_en = 1'b1;
  endtask

  task automatic test_drain_pause();
    int i;
    for (i = 0; i < 40; i++) begin
      send_block(rmx_pkg::action_t'($urandom_range(0, 3)), rand_word(), rand_word(),
                 rand_word(), rand_word());
      if (i == 19) wait_for_drain();
    end
  endtask

  task automatic test_back_to_back();
    int i;
    tx_idle_en  = 1'b0;
    rx_stall_en = 1'b0;
    for (i = 0; i < 300; i++) begin
      send_block(rmx_pkg::action_t'($urandom_range(0, 3)), rand_word(), rand_word(),
                 rand_word(), rand_word());
    end
    tx_idle_en  = 1'b1;
    rx_stall_en = 1'b1;
  endtask

  task automatic test_random_blocks();
    int i;
    for (i = 0; i < 1300; i++) begin
      send_block(rmx_pkg::action_t'($urandom_range(0, 3)), rand_word(), rand_word(),
                 rand_word(), rand_word());
    end
  endtask

  // ---------------------------------------------------------------- receiver

  initial begin : rx_side
    int unsigned pause;
    bit          hold_off_ack;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req != hold_off_ack) begin
        hold_off_ack = hold_off_req;
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        out_ready <= 1'b1;
      end else if (rx_stall_en && $urandom_range(0, 3) == 0) begin
        pause = idle_len();
        out_ready <= 1'b0;
        repeat (pause) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- checking

  always @(posedge clk) begin : check_results
    rmx_pkg::out_beat_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_blocks.size() == 0) begin
        $error("output beat with nothing expected: %h", out_data);
        mismatches++;
      end else begin
        want = expected_blocks.pop_front();
        blocks_checked++;
        if (out_data.word_a_out !== want.word_a_out) begin
          $error("word_a_out: expected %h, got %h", want.word_a_out, out_data.word_a_out);
          mismatches++;
        end
        if (out_data.word_b_out !== want.word_b_out) begin
          $error("word_b_out: expected %h, got %h", want.word_b_out, out_data.word_b_out);
          mismatches++;
        end
        if (out_data.word_c_out !== want.word_c_out) begin
          $error("word_c_out: expected %h, got %h", want.word_c_out, out_data.word_c_out);
          mismatches++;
        end
        if (out_data.word_d_out !== want.word_d_out) begin
          $error("word_d_out: expected %h, got %h", want.word_d_out, out_data.word_d_out);
          mismatches++;
        end
      end
    end
  end

  // no beat moving on either side for too long means a hang
  always @(posedge clk) begin
    if (!rst && ((in_valid && in_ready) || (out_valid && out_ready))) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no beat accepted for %0d cycles", quiet_cycles);
      $display("tb_reversible_128bit_mixer_core NOT OK");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    rst      <= 1'b1;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_extremes();
    test_inverse_pairs();
    test_output_hold_off();
    test_drain_pause();
    test_back_to_back();
    test_random_blocks();
    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_blocks.size() != 0) begin
      $error("%0d expected results never arrived", expected_blocks.size());
    end
    $display("%0d blocks in (mix %0d, unmix %0d, half-forward %0d, half-inverse %0d)",
             blocks_sent, sent_per_action[rmx_pkg::ACT_MIX],
             sent_per_action[rmx_pkg::ACT_UNMIX], sent_per_action[rmx_pkg::ACT_HALF_FWD],
             sent_per_action[rmx_pkg::ACT_HALF_INV]);
    $display("%0d results compared, %0d field mismatches, incl. a full output hold-off",
             blocks_checked, mismatches);
    if (mismatches == 0 && expected_blocks.size() == 0) begin
      $display("tb_reversible_128bit_mixer_core OK");
    end else begin
      $display("tb_reversible_128bit_mixer_core NOT OK");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/rmx_pkg.sv
rtl/rmx_cell.sv
rtl/reversible_128bit_mixer_core.sv
dv/tb_reversible_128bit_mixer_core.sv
